// ===== src/rbl_pkg.sv =====
// ----------------------------------------------------------------------------
// rbl_pkg - shared types and constants for the red/black Laplace sweep
// Beat structs, action codes, register map and reset values.
// ----------------------------------------------------------------------------
package rbl_pkg;

    localparam int DefGridRows = 64;
    localparam int DefGridCols = 256;

    // action codes
    localparam logic [2:0] ActLoadCell = 3'd0;
    localparam logic [2:0] ActLoadTop  = 3'd1;
    localparam logic [2:0] ActLoadBot  = 3'd2;
    localparam logic [2:0] ActSweep    = 3'd3;
    localparam logic [2:0] ActReadCell = 3'd4;

    // register indexes
    localparam logic [2:0] RegRows   = 3'd0;
    localparam logic [2:0] RegCols   = 3'd1;
    localparam logic [2:0] RegOdd    = 3'd2;
    localparam logic [2:0] RegLeft   = 3'd3;
    localparam logic [2:0] RegRight  = 3'd4;
    localparam logic [2:0] RegThresh = 3'd5;

    localparam int PaddrW = 5;

    localparam logic [6:0]  RstRows   = 7'd64;
    localparam logic [8:0]  RstCols   = 9'd256;
    localparam logic [15:0] RstRight  = 16'd25600;
    localparam logic [15:0] RstThresh = 16'd26;

    typedef struct packed {
        logic [2:0]  action;
        logic [5:0]  row;
        logic [7:0]  col;
        logic [15:0] value;
    } t_item;

    typedef struct packed {
        logic [15:0] read_value;
        logic [15:0] max_change;
        logic        converged;
    } t_result;

    typedef struct packed {
        logic [6:0]  rows_in_use;
        logic [8:0]  cols_in_use;
        logic        odd_rank;
        logic [15:0] left_boundary;
        logic [15:0] right_boundary;
        logic [15:0] converge_threshold;
    } t_cfg;

    // write target of the storage
    typedef enum logic [1:0] {
        WR_NONE = 2'd0,
        WR_GRID = 2'd1,
        WR_TOP  = 2'd2,
        WR_BOT  = 2'd3
    } t_wr_sel;

    typedef struct packed {
        t_wr_sel     sel;
        logic [15:0] data;
    } t_wr_ctl;

endpackage

// ===== src/rbl_cfg.sv =====
// ----------------------------------------------------------------------------
// rbl_cfg - configuration registers
// APB-style register file, write on access phase, combinational readback.
// ----------------------------------------------------------------------------
module rbl_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbl_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rbl_pkg::t_cfg              o_cfg
);

    rbl_pkg::t_cfg r_cfg;
    logic [2:0]    idx;

    assign idx    = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rows_in_use        <= rbl_pkg::RstRows;
            r_cfg.cols_in_use        <= rbl_pkg::RstCols;
            r_cfg.odd_rank           <= 1'b0;
            r_cfg.left_boundary      <= 16'd0;
            r_cfg.right_boundary     <= rbl_pkg::RstRight;
            r_cfg.converge_threshold <= rbl_pkg::RstThresh;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                rbl_pkg::RegRows:   r_cfg.rows_in_use        <= pwdata[6:0];
                rbl_pkg::RegCols:   r_cfg.cols_in_use        <= pwdata[8:0];
                rbl_pkg::RegOdd:    r_cfg.odd_rank           <= pwdata[0];
                rbl_pkg::RegLeft:   r_cfg.left_boundary      <= pwdata[15:0];
                rbl_pkg::RegRight:  r_cfg.right_boundary     <= pwdata[15:0];
                rbl_pkg::RegThresh: r_cfg.converge_threshold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            rbl_pkg::RegRows:   prdata = {25'd0, r_cfg.rows_in_use};
            rbl_pkg::RegCols:   prdata = {23'd0, r_cfg.cols_in_use};
            rbl_pkg::RegOdd:    prdata = {31'd0, r_cfg.odd_rank};
            rbl_pkg::RegLeft:   prdata = {16'd0, r_cfg.left_boundary};
            rbl_pkg::RegRight:  prdata = {16'd0, r_cfg.right_boundary};
            rbl_pkg::RegThresh: prdata = {16'd0, r_cfg.converge_threshold};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// ===== src/rbl_store.sv =====
// ----------------------------------------------------------------------------
// rbl_store - grid and halo memories
// One write port, one registered read port per memory; top and bottom halos share an address.
// ----------------------------------------------------------------------------
module rbl_store #(
    parameter int GRID_ROWS = rbl_pkg::DefGridRows,
    parameter int GRID_COLS = rbl_pkg::DefGridCols,
    localparam int AW = $clog2(GRID_ROWS * GRID_COLS),
    localparam int CW = $clog2(GRID_COLS)
) (
    input  logic             i_clk,
    input  rbl_pkg::t_wr_ctl i_wr,
    input  logic [AW-1:0]    i_grid_addr,
    input  logic [CW-1:0]    i_col_addr,
    output logic [15:0]      o_grid_q,
    output logic [15:0]      o_top_q,
    output logic [15:0]      o_bot_q
);

    logic [15:0] grid_mem [GRID_ROWS*GRID_COLS];
    logic [15:0] top_mem  [GRID_COLS];
    logic [15:0] bot_mem  [GRID_COLS];

    always_ff @(posedge i_clk) begin
        if (i_wr.sel == rbl_pkg::WR_GRID) begin
            grid_mem[i_grid_addr] <= i_wr.data;
        end
        o_grid_q <= grid_mem[i_grid_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.sel == rbl_pkg::WR_TOP) begin
            top_mem[i_col_addr] <= i_wr.data;
        end
        o_top_q <= top_mem[i_col_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.sel == rbl_pkg::WR_BOT) begin
            bot_mem[i_col_addr] <= i_wr.data;
        end
        o_bot_q <= bot_mem[i_col_addr];
    end

endmodule

// ===== src/red_black_laplace_sweep.sv =====
// ----------------------------------------------------------------------------
// red_black_laplace_sweep - red/black Gauss-Seidel Laplace relaxation
// Grid plus halo rows, load/read actions and full red-then-black sweeps.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  item     | in        | i_valid / o_ready  | i_item   (rbl_pkg::t_item)
//  result   | out       | o_valid / i_ready  | o_result (rbl_pkg::t_result)
//  config   | in        | psel/penable/pready| paddr, pwdata, prdata
//
//  Loads write on acceptance; a read passes S_RD_CAP and S_DONE to its beat.
//  A sweep steps each active cell through S_OLD to S_WR; one memory
//  read port is shared by the five cell reads, and one adder builds the sum.
//  Reset (synchronous, active low) clears the sequencer and the result valid;
//  memories keep no reset and are valid only once written.
//  A pending result beat stalls only the next read or sweep completion.
// ----------------------------------------------------------------------------
module red_black_laplace_sweep #(
    parameter int GRID_ROWS = rbl_pkg::DefGridRows,
    parameter int GRID_COLS = rbl_pkg::DefGridCols
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  rbl_pkg::t_item             i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output rbl_pkg::t_result           o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rbl_pkg::PaddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int AW = $clog2(GRID_ROWS * GRID_COLS);
    localparam int HW = RW + 1;
    localparam int WW = CW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_CAP, S_OLD, S_UP, S_DN, S_LF, S_RT, S_CALC, S_WR, S_DONE
    } t_state;

    // where the captured operand comes from
    typedef enum logic [1:0] {
        SRC_GRID, SRC_TOP, SRC_BOT, SRC_CONST
    } t_src;

    rbl_pkg::t_cfg    cfg;
    rbl_pkg::t_wr_ctl wr;

    t_state           r_state;
    t_src             r_src, n_src;
    logic [15:0]      r_const, n_const;
    logic [RW-1:0]    r_i;
    logic [CW-1:0]    r_j;
    logic             r_colour;
    logic             r_align;
    logic [HW-1:0]    r_h;
    logic [WW-1:0]    r_w;
    logic [17:0]      r_acc;
    logic [15:0]      r_old;
    logic [15:0]      r_peak;
    logic             r_cell_ok;
    logic             r_ov;
    rbl_pkg::t_result r_pend;   // finished result waiting for the beat register
    rbl_pkg::t_result r_res;

    logic [10:0]   row_x, col_x;
    logic          in_cell_ok, in_col_ok, accept;
    logic [RW-1:0] a_r;
    logic [CW-1:0] a_c;
    logic [AW-1:0] grid_addr;
    logic [15:0]   grid_q, top_q, bot_q, cap;
    logic [17:0]   n_sum;
    logic [15:0]   nv, diff;
    logic          first_row, last_row, first_col, last_col;
    logic [10:0]   h_c, w_c;
    logic          out_free;

    rbl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rbl_store #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr        (wr),
        .i_grid_addr (grid_addr),
        .i_col_addr  (a_c),
        .o_grid_q    (grid_q),
        .o_top_q     (top_q),
        .o_bot_q     (bot_q)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_ov;
    assign o_result = r_res;
    assign out_free = !r_ov || i_ready;

    assign row_x      = 11'(i_item.row);
    assign col_x      = 11'(i_item.col);
    assign in_col_ok  = col_x < 11'(GRID_COLS);
    assign in_cell_ok = in_col_ok && (row_x < 11'(GRID_ROWS));

    // clamp active size into [2, GRID]
    assign h_c = (11'(cfg.rows_in_use) < 11'd2) ? 11'd2 :
                 (11'(cfg.rows_in_use) > 11'(GRID_ROWS)) ? 11'(GRID_ROWS) :
                 11'(cfg.rows_in_use);
    assign w_c = (11'(cfg.cols_in_use) < 11'd2) ? 11'd2 :
                 (11'(cfg.cols_in_use) > 11'(GRID_COLS)) ? 11'(GRID_COLS) :
                 11'(cfg.cols_in_use);

    assign first_row = (r_i == '0);
    assign last_row  = (HW'(r_i) + HW'(1)) == r_h;
    assign first_col = (r_j == '0);
    assign last_col  = (WW'(r_j) + WW'(1)) == r_w;

    // read address and operand source per step
    always_comb begin
        a_r     = r_i;
        a_c     = r_j;
        n_src   = SRC_GRID;
        n_const = cfg.left_boundary;
        case (r_state)
            S_IDLE: begin
                a_r = row_x[RW-1:0];
                a_c = col_x[CW-1:0];
            end
            S_UP: begin
                a_r   = r_i - RW'(1);
                n_src = first_row ? SRC_TOP : SRC_GRID;
            end
            S_DN: begin
                a_r   = r_i + RW'(1);
                n_src = last_row ? SRC_BOT : SRC_GRID;
            end
            S_LF: begin
                a_c   = r_j - CW'(1);
                n_src = first_col ? SRC_CONST : SRC_GRID;
            end
            S_RT: begin
                a_c     = r_j + CW'(1);
                n_src   = last_col ? SRC_CONST : SRC_GRID;
                n_const = cfg.right_boundary;
            end
            default: ;
        endcase
    end

    assign grid_addr = AW'(a_r) * AW'(GRID_COLS) + AW'(a_c);

    always_comb begin
        case (r_src)
            SRC_GRID: cap = grid_q;
            SRC_TOP:  cap = top_q;
            SRC_BOT:  cap = bot_q;
            default:  cap = r_const;
        endcase
    end

    // shared adder: starts fresh on the first neighbor
    assign n_sum = ((r_state == S_DN) ? 18'd0 : r_acc) + 18'(cap);
    assign nv    = r_acc[17:2];
    assign diff  = (r_old > nv) ? (r_old - nv) : (nv - r_old);

    always_comb begin
        wr.sel  = rbl_pkg::WR_NONE;
        wr.data = i_item.value;
        if (accept) begin
            case (i_item.action)
                rbl_pkg::ActLoadCell: if (in_cell_ok) wr.sel = rbl_pkg::WR_GRID;
                rbl_pkg::ActLoadTop:  if (in_col_ok)  wr.sel = rbl_pkg::WR_TOP;
                rbl_pkg::ActLoadBot:  if (in_col_ok)  wr.sel = rbl_pkg::WR_BOT;
                default: ;
            endcase
        end else if (r_state == S_WR) begin
            wr.sel  = rbl_pkg::WR_GRID;
            wr.data = nv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) r_ov <= 1'b1;
            else if (r_ov && i_ready)          r_ov <= 1'b0;
            r_src   <= n_src;
            r_const <= n_const;
            unique case (r_state)
                S_IDLE: begin
                    r_cell_ok <= in_cell_ok;
                    if (accept && i_item.action == rbl_pkg::ActReadCell) begin
                        r_state <= S_RD_CAP;
                    end else if (accept && i_item.action == rbl_pkg::ActSweep) begin
                        r_h      <= HW'(h_c);
                        r_w      <= WW'(w_c);
                        r_align  <= h_c[0] & cfg.odd_rank;
                        r_colour <= 1'b0;
                        r_i      <= '0;
                        r_j      <= CW'(h_c[0] & cfg.odd_rank);
                        r_peak   <= 16'd0;
                        r_state  <= S_OLD;
                    end
                end
                S_RD_CAP: begin
                    r_pend.read_value <= r_cell_ok ? grid_q : 16'd0;
                    r_pend.max_change <= 16'd0;
                    r_pend.converged  <= 1'b0;
                    r_state           <= S_DONE;
                end
                S_OLD: r_state <= S_UP;
                S_UP: begin
                    r_old   <= grid_q;
                    r_state <= S_DN;
                end
                S_DN: begin
                    r_acc   <= n_sum;
                    r_state <= S_LF;
                end
                S_LF: begin
                    r_acc   <= n_sum;
                    r_state <= S_RT;
                end
                S_RT: begin
                    r_acc   <= n_sum;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_acc   <= n_sum;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (diff > r_peak) r_peak <= diff;
                    r_state <= S_OLD;
                    if ((WW'(r_j) + WW'(2)) < r_w) begin
                        r_j <= r_j + CW'(2);
                    end else if (!last_row) begin
                        r_i <= r_i + RW'(1);
                        r_j <= CW'({~r_i[0] ^ r_align ^ r_colour});
                    end else if (!r_colour) begin
                        r_colour <= 1'b1;
                        r_i      <= '0;
                        r_j      <= CW'({~r_align});
                    end else begin
                        r_pend.read_value <= 16'd0;
                        r_pend.max_change <= (diff > r_peak) ? diff : r_peak;
                        r_pend.converged  <= ((diff > r_peak) ? diff : r_peak)
                                             <= cfg.converge_threshold;
                        r_state           <= S_DONE;
                    end
                end
                S_DONE: begin
                    // result register frees up: move the finished beat out
                    if (out_free) begin
                        r_res   <= r_pend;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_wr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.sel != rbl_pkg::WR_NONE) |-> (r_state == S_IDLE || r_state == S_WR))
        else $error("store written outside idle or write step");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OLD) |-> (HW'(r_i) < r_h && WW'(r_j) < r_w))
        else $error("sweep cell outside active region");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_res)))
        else $error("result beat changed while stalled");

    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_ov && r_state == S_IDLE))
        else $error("finished result not presented");
`endif

endmodule
